/* sv/hbbc_pkg.sv */
// ----------------------------------------------------------------------------
// hbbc_pkg
// Shared types and constants for the hashed block buffer cache.
// ----------------------------------------------------------------------------
package hbbc_pkg;

  localparam int DefWays = 32;
  localparam int DefSets = 13;

  localparam logic [1:0] MODE_READ    = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_PIN     = 2'd2;
  localparam logic [1:0] MODE_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FILL     = 2'd1;
  localparam logic [1:0] ST_NOFREE   = 2'd2;
  localparam logic [1:0] ST_COUNTERR = 2'd3;

  // one way entry as held in the row memory
  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic        vld;
    logic [7:0]  cnt;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

/* sv/hbbc_ram.sv */
// ----------------------------------------------------------------------------
// hbbc_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* sv/hashed_block_buffer_cache_core.sv */
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_core
// Buffer cache bookkeeping: tags, valid bits, reference counts, recency.
// ----------------------------------------------------------------------------
// A read goes through these steps after acceptance: byte-weighted fold of the
// block number (registered at acceptance), remainder by reciprocal multiply,
// row read (registered read data), then compare and write back. Release, pin
// and unpin skip the remainder step. One request at a time: a new request
// waits until the last one is done and its result is not held by an output stall.
// Reset clears the control state and starts a clearing pass over every row
// of the set memory, during which no request is accepted.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache_core #(
  parameter int WAYS = hbbc_pkg::DefWays,
  parameter int SETS = hbbc_pkg::DefSets
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [3:0]  set_index,
  input  logic [4:0]  way_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  result_set,
  output logic [4:0]  result_way,
  output logic [1:0]  status
);
  import hbbc_pkg::*;

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RW = WW;
  localparam int RowW = WAYS * (EntryW + RW);

  // residues of the byte weights 2^(8k) and the reciprocal for the remainder
  localparam int FW0 = 1 % SETS;
  localparam int FW1 = 256 % SETS;
  localparam int FW2 = 65536 % SETS;
  localparam int FW3 = 16777216 % SETS;
  localparam int RK  = 16 + $clog2(SETS);
  localparam int RM  = ((1 << RK) + SETS - 1) / SETS;

  typedef struct packed {
    entry_t [WAYS-1:0]         e;
    logic [WAYS-1:0][RW-1:0]   r;
  } row_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_READ  = 5'b01000,
    S_EXEC  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [SW-1:0] clr_idx;
  logic [1:0]  q_mode;
  logic [7:0]  q_dev;
  logic [31:0] q_blk;
  logic [3:0]  q_set;
  logic [4:0]  q_way;
  logic [SW-1:0] row_addr;

  logic        we;
  logic [SW-1:0] waddr;
  row_t        wrow, rrow, rst_row;
  logic [RowW-1:0] rdata;

  hbbc_ram #(.Width(RowW), .Depth(SETS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrow),
    .raddr(row_addr), .rdata(rdata)
  );
  assign rrow = row_t'(rdata);

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rst_row.e[i] = '0;
      rst_row.r[i] = RW'(i);
    end
  end

  wire accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  // set of a read: bytes folded by their residues, then exact remainder
  logic [15:0]   fold_sum, fold_next, mod_quo, mod_rem;
  logic [38:0]   mod_prod;
  logic [SW-1:0] blk_set;
  assign fold_next = 16'(block_number[7:0])   * 16'(FW0) +
                     16'(block_number[15:8])  * 16'(FW1) +
                     16'(block_number[23:16]) * 16'(FW2) +
                     16'(block_number[31:24]) * 16'(FW3);
  assign mod_prod = 39'(fold_sum) * 39'(RM);
  assign mod_quo  = 16'(mod_prod >> RK);
  assign mod_rem  = fold_sum - mod_quo * 16'(SETS);
  assign blk_set  = SW'(mod_rem);

  // ---- execute stage ----
  logic          hit_f, free_f;
  logic [WW-1:0] hit_w, free_w;
  logic [RW-1:0] hit_r, free_r;
  logic          range_ok;
  logic [WW-1:0] tw;
  entry_t        te;
  logic [1:0]    st;
  logic [4:0]    o_way;
  logic          do_wr;
  row_t          nrow;

  always_comb begin
    hit_f = 1'b0; free_f = 1'b0;
    hit_w = '0; free_w = '0; hit_r = '0; free_r = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (rrow.e[i].dev == q_dev && rrow.e[i].blk == q_blk &&
          (!hit_f || rrow.r[i] > hit_r)) begin
        hit_f = 1'b1; hit_w = WW'(i); hit_r = rrow.r[i];
      end
      if (rrow.e[i].cnt == 8'd0 && (!free_f || rrow.r[i] < free_r)) begin
        free_f = 1'b1; free_w = WW'(i); free_r = rrow.r[i];
      end
    end
    range_ok = (32'(q_set) < 32'(SETS)) && (32'(q_way) < 32'(WAYS));
    tw = WW'(q_way);
    nrow = rrow;
    do_wr = 1'b0;
    st = ST_OK;
    o_way = q_way;
    te = rrow.e[tw];
    if (q_mode == MODE_READ) begin
      if (hit_f) begin
        te = rrow.e[hit_w];
        o_way = 5'(hit_w);
        if (te.cnt == 8'hff) st = ST_COUNTERR;
        else begin
          st = te.vld ? ST_OK : ST_FILL;
          nrow.e[hit_w].cnt = te.cnt + 8'd1;
          nrow.e[hit_w].vld = 1'b1;
          do_wr = 1'b1;
        end
      end else if (free_f) begin
        o_way = 5'(free_w);
        st = ST_FILL;
        nrow.e[free_w] = '{dev: q_dev, blk: q_blk, vld: 1'b1, cnt: 8'd1};
        do_wr = 1'b1;
      end else begin
        o_way = '0;
        st = ST_NOFREE;
      end
    end else if (!range_ok) begin
      st = ST_COUNTERR;
    end else if (q_mode == MODE_PIN) begin
      if (te.cnt == 8'hff) st = ST_COUNTERR;
      else begin
        nrow.e[tw].cnt = te.cnt + 8'd1;
        do_wr = 1'b1;
      end
    end else if (te.cnt == 8'd0) begin
      st = ST_COUNTERR;
    end else begin
      nrow.e[tw].cnt = te.cnt - 8'd1;
      do_wr = 1'b1;
      if (q_mode == MODE_RELEASE && te.cnt == 8'd1) begin
        for (int i = 0; i < WAYS; i++)
          if (rrow.r[i] > rrow.r[tw]) nrow.r[i] = rrow.r[i] - RW'(1);
        nrow.r[tw] = RW'(WAYS - 1);
      end
    end
  end

  always_comb begin
    we = 1'b0; waddr = row_addr; wrow = nrow;
    if (state == S_CLEAR) begin
      we = 1'b1; waddr = clr_idx; wrow = rst_row;
    end else if (state == S_EXEC) begin
      we = do_wr;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (32'(clr_idx) == SETS - 1) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = (mode == MODE_READ) ? S_MOD : S_READ;
      S_MOD:   state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + SW'(1);
      if (state == S_EXEC) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mode <= mode; q_dev <= device; q_blk <= block_number;
      q_set <= set_index;
      q_way <= way_index;
      row_addr <= SW'(set_index);
      fold_sum <= fold_next;
    end else if (state == S_MOD) begin
      q_set <= 4'(blk_set);
      row_addr <= blk_set;
    end
    if (state == S_EXEC) begin
      result_set <= q_set; result_way <= o_way; status <= st;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !accept) else $error("request taken while busy");
  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> out_valid) else $error("result missing");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_READ) |-> !we) else $error("stray write");

endmodule

/* tb/tb_hashed_block_buffer_cache_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_block_buffer_cache_core
// Self-checking bench for the buffer cache bookkeeping core. A directed table
// and directed sequences cover the corner cases (full sets, saturated counts,
// bad indexes); random traffic biased towards a small pool of blocks follows. Every result
// is compared against a behavioural model of the cache state.
// ----------------------------------------------------------------------------
module tb_hashed_block_buffer_cache_core;
  import hbbc_pkg::*;

  localparam int WAYS = DefWays;
  localparam int SETS = DefSets;

  typedef struct packed {
    logic [3:0] set_no;
    logic [4:0] way_no;
    logic [1:0] st;
  } resp_t;

  typedef struct {
    logic [1:0]  md;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [3:0]  si;
    logic [4:0]  wi;
    bit          has_exp;
    resp_t       exp_resp;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_READ;
  logic [7:0]  device = '0;
  logic [31:0] block_number = '0;
  logic [3:0]  set_index = '0;
  logic [4:0]  way_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  result_set;
  logic [4:0]  result_way;
  logic [1:0]  status;

  hashed_block_buffer_cache_core u_dut (
    .clk, .rst, .in_valid, .in_stall, .mode, .device, .block_number,
    .set_index, .way_index, .out_valid, .out_stall, .result_set, .result_way,
    .status
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model of the cache state
  logic [7:0]  m_dev  [SETS][WAYS];
  logic [31:0] m_blk  [SETS][WAYS];
  bit          m_vld  [SETS][WAYS];
  int          m_cnt  [SETS][WAYS];
  int          m_rank [SETS][WAYS];

  resp_t       pending_resp[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  function automatic resp_t cache_lookup(logic [1:0] md, logic [7:0] dev,
                                         logic [31:0] blk, logic [3:0] si,
                                         logic [4:0] wi);
    int s, hit, hit_r, fr, fr_r, c, old;
    resp_t r;
    if (md == MODE_READ) begin
      s = blk % SETS;
      hit = -1; hit_r = -1; fr = -1; fr_r = WAYS;
      for (int i = 0; i < WAYS; i++) begin
        if (m_dev[s][i] == dev && m_blk[s][i] == blk && m_rank[s][i] > hit_r) begin
          hit = i; hit_r = m_rank[s][i];
        end
        if (m_cnt[s][i] == 0 && m_rank[s][i] < fr_r) begin
          fr = i; fr_r = m_rank[s][i];
        end
      end
      r.set_no = 4'(s);
      if (hit >= 0) begin
        r.way_no = 5'(hit);
        if (m_cnt[s][hit] == 255) begin
          r.st = ST_COUNTERR;
        end else begin
          m_cnt[s][hit]++;
          r.st = m_vld[s][hit] ? ST_OK : ST_FILL;
          m_vld[s][hit] = 1'b1;
        end
      end else if (fr >= 0) begin
        r.way_no = 5'(fr);
        m_dev[s][fr] = dev; m_blk[s][fr] = blk;
        m_cnt[s][fr] = 1; m_vld[s][fr] = 1'b1;
        r.st = ST_FILL;
      end else begin
        r.way_no = '0;
        r.st = ST_NOFREE;
      end
      return r;
    end
    r.set_no = si; r.way_no = wi; r.st = ST_COUNTERR;
    if (si >= SETS || wi >= WAYS) return r;
    c = m_cnt[si][wi];
    if (md == MODE_PIN) begin
      if (c == 255) return r;
      m_cnt[si][wi] = c + 1;
      r.st = ST_OK;
      return r;
    end
    if (c == 0) return r;
    m_cnt[si][wi] = c - 1;
    if (md == MODE_RELEASE && c == 1) begin
      old = m_rank[si][wi];
      for (int i = 0; i < WAYS; i++)
        if (m_rank[si][i] > old) m_rank[si][i]--;
      m_rank[si][wi] = WAYS - 1;
    end
    r.st = ST_OK;
    return r;
  endfunction

  // valid stays high after acceptance; the caller drops it before draining
  task automatic issue_request(req_row_t rq);
    resp_t r;
    r = cache_lookup(rq.md, rq.dev, rq.blk, rq.si, rq.wi);
    if (rq.has_exp && r !== rq.exp_resp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with model: table %h model %h", rq.exp_resp, r);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= rq.md; device <= rq.dev; block_number <= rq.blk;
    set_index <= rq.si; way_index <= rq.wi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_resp.push_back(r);
    @(negedge clk);
  endtask

  // response checker
  always @(posedge clk) begin
    resp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h", result_set,
                                       result_way, status);
      end else begin
        e = pending_resp.pop_front();
        if (result_set !== e.set_no || result_way !== e.way_no || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected set %0d way %0d status %0d, got %0d %0d %0d",
                     e.set_no, e.way_no, e.st, result_set, result_way, status);
        end
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic req_row_t mk(logic [1:0] md, logic [7:0] dev, logic [31:0] blk,
                                  logic [3:0] si, logic [4:0] wi);
    req_row_t q;
    q.md = md; q.dev = dev; q.blk = blk; q.si = si; q.wi = wi; q.has_exp = 0;
    q.exp_resp = '0;
    return q;
  endfunction

  function automatic req_row_t mkx(logic [1:0] md, logic [7:0] dev, logic [31:0] blk,
                                   logic [3:0] si, logic [4:0] wi, logic [3:0] es,
                                   logic [4:0] ew, logic [1:0] est);
    req_row_t q;
    q = mk(md, dev, blk, si, wi);
    q.has_exp = 1; q.exp_resp = {es, ew, est};
    return q;
  endfunction

  initial begin
    #400000;
    $display("FAIL hashed_block_buffer_cache_core");
    $finish;
  end

  initial begin
    req_row_t dir_table[$];
    req_row_t q;
    int n, pool_blk, pool_dev;
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) begin
        m_dev[s][w] = '0; m_blk[s][w] = '0; m_vld[s][w] = 0;
        m_cnt[s][w] = 0; m_rank[s][w] = w;
      end
    dir_table.push_back(mkx(MODE_READ, 8'd0, 32'd0, 4'd0, 5'd0, 4'd0, 5'd31, ST_FILL));
    dir_table.push_back(mkx(MODE_READ, 8'd0, 32'd0, 4'd0, 5'd0, 4'd0, 5'd31, ST_OK));
    dir_table.push_back(mkx(MODE_READ, 8'hff, 32'hffffffff, 4'hf, 5'h1f, 4'd8, 5'd0,
                            ST_FILL));
    dir_table.push_back(mkx(MODE_RELEASE, 8'd0, 32'd0, 4'd5, 5'd0, 4'd5, 5'd0,
                            ST_COUNTERR));
    dir_table.push_back(mkx(MODE_UNPIN, 8'hff, 32'hffffffff, 4'd12, 5'd31, 4'd12, 5'd31,
                            ST_COUNTERR));
    dir_table.push_back(mkx(MODE_PIN, 8'd0, 32'd0, 4'd13, 5'd0, 4'd13, 5'd0, ST_COUNTERR));
    dir_table.push_back(mkx(MODE_RELEASE, 8'd0, 32'd0, 4'd15, 5'd31, 4'd15, 5'd31,
                            ST_COUNTERR));
    dir_table.push_back(mkx(MODE_PIN, 8'd0, 32'd0, 4'd1, 5'd2, 4'd1, 5'd2, ST_OK));
    dir_table.push_back(mkx(MODE_UNPIN, 8'd0, 32'd0, 4'd1, 5'd2, 4'd1, 5'd2, ST_OK));
    dir_table.push_back(mk(MODE_RELEASE, 8'd0, 32'd0, 4'd0, 5'd31));
    dir_table.push_back(mk(MODE_RELEASE, 8'd0, 32'd0, 4'd0, 5'd31));
    dir_table.push_back(mk(MODE_READ, 8'd0, 32'd0, 4'd0, 5'd0));
    dir_table.push_back(mk(MODE_READ, 8'd7, 32'd0, 4'd0, 5'd0));

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    foreach (dir_table[i]) issue_request(dir_table[i]);

    // fill set 2 completely, then one more read must find no free buffer
    for (int w = 0; w < WAYS; w++)
      issue_request(mk(MODE_READ, 8'd1, 32'd2 + 13 * w, 4'd0, 5'd0));
    issue_request(mk(MODE_READ, 8'd1, 32'd2 + 13 * 40, 4'd0, 5'd0));
    // saturate one count with pins; pin and hit-read then overflow
    for (int k = 0; k < 256; k++) issue_request(mk(MODE_PIN, 8'd0, 32'd0, 4'd2, 5'd4));
    issue_request(mk(MODE_READ, 8'd1, 32'd2 + 13 * 4, 4'd0, 5'd0));
    for (int k = 0; k < 256; k++) issue_request(mk(MODE_UNPIN, 8'd0, 32'd0, 4'd2, 5'd4));
    for (int w = 0; w < WAYS; w++)
      issue_request(mk(MODE_RELEASE, 8'd0, 32'd0, 4'd2, 5'(w)));

    // drain before random traffic
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0; end
        1: begin send_idle_pct = 59; stall_pct = 0; end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      for (n = 0; n < 280; n++) begin
        pool_blk = $urandom_range(40);
        pool_dev = $urandom_range(2);
        q = mk(2'($urandom_range(3)), 8'(pool_dev), 32'(pool_blk), 4'(pool_blk % SETS),
               5'($urandom_range(7)));
        if ($urandom_range(9) == 0) begin
          q.dev = 8'($urandom); q.blk = $urandom; q.si = 4'($urandom);
          q.wi = 5'($urandom);
        end
        // bias away from pins, towards reads, so buffers cycle
        if (q.md == MODE_PIN && $urandom_range(1)) q.md = MODE_READ;
        issue_request(q);
      end
      in_valid <= 1'b0;
      while (pending_resp.size() != 0) @(negedge clk);
      stall_pct = 0;
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_resp.size() == 0)
      $display("PASS hashed_block_buffer_cache_core");
    else
      $display("FAIL hashed_block_buffer_cache_core");
    $finish;
  end

endmodule

/* hashed_block_buffer_cache_core.f */
sv/hbbc_pkg.sv
sv/hbbc_ram.sv
sv/hashed_block_buffer_cache_core.sv
tb/tb_hashed_block_buffer_cache_core.sv
